[hdl/pisc_pkg.sv]
// Package: widths, register codes, sequencer states and fixed-point helpers for the PI speed loop.
`timescale 1ns / 1ps
package pisc_pkg;

	localparam int SPEED_W    = 20;
	localparam int ERR_W      = 21;
	localparam int GAIN_W     = 24;
	localparam int LIMIT_W    = 23;
	localparam int MUL_A_W    = 26;
	localparam int PROD_W     = MUL_A_W + GAIN_W + 1;
	localparam int WIDE_W     = 52;
	localparam int FRAC_W     = 16;
	localparam int TRUNC_W    = 36;
	localparam int INTEG_W    = 48;
	localparam int CO_W       = 24;
	localparam int DUTY_W     = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MAX_DUTY_DEF      = 4200;
	localparam int MAX_PROP_TERM_DEF = 1400;
	localparam int DUTY_FIELD_MAX    = (1 << (DUTY_W - 1)) - 1;
	localparam int DUTY_FIELD_MIN    = -(1 << (DUTY_W - 1));

	localparam logic signed [WIDE_W-1:0] INTEG_HI = (52'sd1 <<< (INTEG_W - 1)) - 52'sd1;
	localparam logic signed [WIDE_W-1:0] INTEG_LO = -(52'sd1 <<< (INTEG_W - 1));
	localparam logic signed [TRUNC_W-1:0] CO_HI  = (36'sd1 <<< (CO_W - 1)) - 36'sd1;
	localparam logic signed [TRUNC_W-1:0] CO_LO  = -(36'sd1 <<< (CO_W - 1));

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP,
		REG_KI,
		REG_WINDUP,
		REG_SAT_LIMIT,
		REG_DRIVE,
		REG_BRAKE
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp_gain;
		logic [GAIN_W-1:0]  ki_gain;
		logic [GAIN_W-1:0]  windup_gain;
		logic [LIMIT_W-1:0] saturation_limit;
		logic [GAIN_W-1:0]  drive_gain;
		logic [GAIN_W-1:0]  brake_gain;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_P,
		ST_PROP,
		ST_CO,
		ST_WIND,
		ST_ACC_I,
		ST_ACC_W,
		ST_DUTY
	} state_t;

	// Q.16 to integer, truncated toward zero
	function automatic logic signed [TRUNC_W-1:0] trunc_q16(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] q;
		q = v >>> FRAC_W;
		if (v[WIDE_W-1] && (v[FRAC_W-1:0] != '0))
			q = q + 52'sd1;
		return q[TRUNC_W-1:0];
	endfunction

endpackage

[hdl/pisc_if.sv]
// Interfaces: speed item channel and control result channel.
`timescale 1ns / 1ps
interface pisc_in_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pisc_pkg::SPEED_W-1:0]      demanded_speed;
	logic signed [pisc_pkg::SPEED_W-1:0]      measured_speed;

	modport source (output valid, demanded_speed, measured_speed, input ready);
	modport sink   (input valid, demanded_speed, measured_speed, output ready);
endinterface

interface pisc_out_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [pisc_pkg::CO_W-1:0]         control_output;
	logic signed [pisc_pkg::DUTY_W-1:0]       duty;

	modport source (output valid, control_output, duty, input ready);
	modport sink   (input valid, control_output, duty, output ready);
endinterface

[hdl/pisc_mul.sv]
// Shared signed-by-unsigned multiplier with registered product.
`timescale 1ns / 1ps
module pisc_mul (
	input  logic                                  clk,
	input  logic signed [pisc_pkg::MUL_A_W-1:0]   a,
	input  logic        [pisc_pkg::GAIN_W-1:0]    b,
	output logic signed [pisc_pkg::PROD_W-1:0]    p_q
);

	always_ff @(posedge clk) begin
		p_q <= a * $signed({1'b0, b});
	end

endmodule

[hdl/pisc_cfg.sv]
// Configuration register file: gains and saturation limit.
`timescale 1ns / 1ps
module pisc_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pisc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [pisc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output pisc_pkg::cfg_t                       cfg
);

	pisc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q                  <= '0;
			cfg_q.saturation_limit <= '1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				pisc_pkg::REG_KP:        cfg_q.kp_gain          <= cfg_data;
				pisc_pkg::REG_KI:        cfg_q.ki_gain          <= cfg_data;
				pisc_pkg::REG_WINDUP:    cfg_q.windup_gain      <= cfg_data;
				pisc_pkg::REG_SAT_LIMIT: cfg_q.saturation_limit <= cfg_data[pisc_pkg::LIMIT_W-1:0];
				pisc_pkg::REG_DRIVE:     cfg_q.drive_gain       <= cfg_data;
				pisc_pkg::REG_BRAKE:     cfg_q.brake_gain       <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/pi_speed_control_antiwindup.sv]
// Top level: PI speed controller with back-calculation anti-windup and duty mapping.
// After acceptance the sequencer runs MUL_P, PROP, CO, WIND, ACC_I, ACC_W and DUTY, then IDLE;
// items are taken only in IDLE. One shared multiplier serves the proportional,
// integral, windup and duty products in turn under the sequencer.
// A new item is taken while the previous result still waits; a full output holds the duty step.
// Reset (arst_n low): integral cleared, gains zero, saturation limit all ones, no result.
`timescale 1ns / 1ps
module pi_speed_control_antiwindup #(
	parameter int MAX_DUTY      = pisc_pkg::MAX_DUTY_DEF,
	parameter int MAX_PROP_TERM = pisc_pkg::MAX_PROP_TERM_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	pisc_in_if.sink                          in_ch,
	pisc_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [pisc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pisc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int TW = pisc_pkg::TRUNC_W;
	localparam int WW = pisc_pkg::WIDE_W;
	localparam int DUTY_HI_I = (MAX_DUTY > pisc_pkg::DUTY_FIELD_MAX) ?
		pisc_pkg::DUTY_FIELD_MAX : MAX_DUTY;
	localparam int DUTY_LO_I = (-MAX_DUTY < pisc_pkg::DUTY_FIELD_MIN) ?
		pisc_pkg::DUTY_FIELD_MIN : -MAX_DUTY;
	localparam logic signed [TW-1:0] DUTY_HI  = TW'(DUTY_HI_I);
	localparam logic signed [TW-1:0] DUTY_LO  = TW'(DUTY_LO_I);
	localparam logic signed [TW-1:0] PROP_MAX = TW'(MAX_PROP_TERM);

	pisc_pkg::cfg_t   cfg;
	pisc_pkg::state_t state_q, state_d;

	logic signed [pisc_pkg::ERR_W-1:0]    err_q;
	logic signed [TW-1:0]                 prop_q;
	logic signed [pisc_pkg::CO_W-1:0]     co_q;
	logic signed [pisc_pkg::MUL_A_W-1:0]  windup_q;
	logic signed [WW-1:0]                 acc_q;
	logic signed [pisc_pkg::INTEG_W-1:0]  integ_q;
	logic                                 out_valid_q;
	logic signed [pisc_pkg::CO_W-1:0]     out_co_q;
	logic signed [pisc_pkg::DUTY_W-1:0]   out_duty_q;

	logic signed [pisc_pkg::MUL_A_W-1:0]  mul_a;
	logic        [pisc_pkg::GAIN_W-1:0]   mul_b;
	logic signed [pisc_pkg::PROD_W-1:0]   prod_q;
	logic signed [WW-1:0]                 prod_w;

	logic signed [TW-1:0]                 p_trunc;
	logic signed [WW-1:0]                 co_sum;
	logic signed [TW-1:0]                 co_trunc;
	logic signed [pisc_pkg::CO_W:0]       co_x;
	logic signed [pisc_pkg::CO_W:0]       lim_x;
	logic signed [WW-1:0]                 integ_sum;
	logic                                 in_fire;
	logic                                 out_free;

	pisc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pisc_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	assign in_ch.ready = (state_q == pisc_pkg::ST_IDLE);
	assign in_fire     = in_ch.valid && in_ch.ready;
	assign out_free    = !out_valid_q || out_ch.ready;

	assign prod_w    = WW'(prod_q);
	assign p_trunc   = pisc_pkg::trunc_q16(prod_w);
	assign co_sum    = (WW'(prop_q) <<< pisc_pkg::FRAC_W) + WW'(integ_q);
	assign co_trunc  = pisc_pkg::trunc_q16(co_sum);
	assign co_x      = (pisc_pkg::CO_W + 1)'(co_q);
	assign lim_x     = $signed({2'b00, cfg.saturation_limit});
	assign integ_sum = acc_q + prod_w;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			pisc_pkg::ST_MUL_P: begin
				mul_a = pisc_pkg::MUL_A_W'(err_q);
				mul_b = cfg.kp_gain;
			end
			pisc_pkg::ST_WIND: begin
				mul_a = pisc_pkg::MUL_A_W'(err_q);
				mul_b = cfg.ki_gain;
			end
			pisc_pkg::ST_ACC_I: begin
				mul_a = windup_q;
				mul_b = cfg.windup_gain;
			end
			pisc_pkg::ST_ACC_W: begin
				mul_a = pisc_pkg::MUL_A_W'(co_q);
				mul_b = co_q[pisc_pkg::CO_W-1] ? cfg.brake_gain : cfg.drive_gain;
			end
			// keep the duty product steady while the output is full
			pisc_pkg::ST_DUTY: begin
				mul_a = pisc_pkg::MUL_A_W'(co_q);
				mul_b = co_q[pisc_pkg::CO_W-1] ? cfg.brake_gain : cfg.drive_gain;
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			pisc_pkg::ST_IDLE:  if (in_fire) state_d = pisc_pkg::ST_MUL_P;
			pisc_pkg::ST_MUL_P: state_d = pisc_pkg::ST_PROP;
			pisc_pkg::ST_PROP:  state_d = pisc_pkg::ST_CO;
			pisc_pkg::ST_CO:    state_d = pisc_pkg::ST_WIND;
			pisc_pkg::ST_WIND:  state_d = pisc_pkg::ST_ACC_I;
			pisc_pkg::ST_ACC_I: state_d = pisc_pkg::ST_ACC_W;
			pisc_pkg::ST_ACC_W: state_d = pisc_pkg::ST_DUTY;
			pisc_pkg::ST_DUTY:  if (out_free) state_d = pisc_pkg::ST_IDLE;
			default:            state_d = pisc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pisc_pkg::ST_IDLE;
			integ_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == pisc_pkg::ST_ACC_W) begin
				if (integ_sum > pisc_pkg::INTEG_HI)
					integ_q <= pisc_pkg::INTEG_HI[pisc_pkg::INTEG_W-1:0];
				else if (integ_sum < pisc_pkg::INTEG_LO)
					integ_q <= pisc_pkg::INTEG_LO[pisc_pkg::INTEG_W-1:0];
				else
					integ_q <= integ_sum[pisc_pkg::INTEG_W-1:0];
			end
			if (state_q == pisc_pkg::ST_DUTY && out_free)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			err_q <= pisc_pkg::ERR_W'(in_ch.demanded_speed) - pisc_pkg::ERR_W'(in_ch.measured_speed);
		if (state_q == pisc_pkg::ST_PROP)
			prop_q <= (p_trunc > PROP_MAX) ? PROP_MAX : p_trunc;
		if (state_q == pisc_pkg::ST_CO) begin
			if (co_trunc > pisc_pkg::CO_HI)
				co_q <= pisc_pkg::CO_HI[pisc_pkg::CO_W-1:0];
			else if (co_trunc < pisc_pkg::CO_LO)
				co_q <= pisc_pkg::CO_LO[pisc_pkg::CO_W-1:0];
			else
				co_q <= co_trunc[pisc_pkg::CO_W-1:0];
		end
		if (state_q == pisc_pkg::ST_WIND) begin
			if (co_x > lim_x)
				windup_q <= pisc_pkg::MUL_A_W'(lim_x - co_x);
			else if (co_x < -lim_x)
				windup_q <= pisc_pkg::MUL_A_W'(-lim_x - co_x);
			else
				windup_q <= '0;
		end
		if (state_q == pisc_pkg::ST_ACC_I)
			acc_q <= WW'(integ_q) + prod_w;
		if (state_q == pisc_pkg::ST_DUTY && out_free) begin
			out_co_q <= co_q;
			if (p_trunc > DUTY_HI)
				out_duty_q <= DUTY_HI[pisc_pkg::DUTY_W-1:0];
			else if (p_trunc < DUTY_LO)
				out_duty_q <= DUTY_LO[pisc_pkg::DUTY_W-1:0];
			else
				out_duty_q <= p_trunc[pisc_pkg::DUTY_W-1:0];
		end
	end

	assign out_ch.valid          = out_valid_q;
	assign out_ch.control_output = out_co_q;
	assign out_ch.duty           = out_duty_q;

endmodule

[hdl/pisc_chk.sv]
// Port checker for the PI speed controller and its bind to the top level.
`timescale 1ns / 1ps
module pisc_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [pisc_pkg::CO_W-1:0]    control_output,
	input logic signed [pisc_pkg::DUTY_W-1:0]  duty
);

	a_busy_after_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after an item");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(control_output) && $stable(duty))
		else $error("stalled result changed");

	a_brake_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && control_output < 0 |-> duty <= 0)
		else $error("braking output with positive duty");

	a_drive_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && control_output >= 0 |-> duty >= 0)
		else $error("drive output with negative duty");

endmodule

bind pi_speed_control_antiwindup pisc_chk u_pisc_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_ch.valid),
	.in_ready       (in_ch.ready),
	.out_valid      (out_ch.valid),
	.out_ready      (out_ch.ready),
	.control_output (out_ch.control_output),
	.duty           (out_ch.duty)
);

[tb/pisc_score_pkg.sv]
// Scoreboard for the PI speed loop: predicts control output and duty per item and checks results.
`timescale 1ns / 1ps
package pisc_score_pkg;
	import pisc_pkg::*;

	localparam longint Q16_ONE = longint'(1) <<< FRAC_W;

	typedef struct packed {
		logic signed [CO_W-1:0]   control_output;
		logic signed [DUTY_W-1:0] duty;
	} control_result_t;

	class pi_loop_scoreboard;
		logic [GAIN_W-1:0]  kp, ki, kw, drive, brake;
		logic [LIMIT_W-1:0] sat_limit;
		longint             integral;
		control_result_t    expected_controls[$];
		int                 results_seen;
		int                 fails;

		function new();
			kp = '0;
			ki = '0;
			kw = '0;
			drive = '0;
			brake = '0;
			sat_limit = '1;
			integral = 0;
			results_seen = 0;
			fails = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				REG_KP:        kp = val[GAIN_W-1:0];
				REG_KI:        ki = val[GAIN_W-1:0];
				REG_WINDUP:    kw = val[GAIN_W-1:0];
				REG_SAT_LIMIT: sat_limit = val[LIMIT_W-1:0];
				REG_DRIVE:     drive = val[GAIN_W-1:0];
				REG_BRAKE:     brake = val[GAIN_W-1:0];
				default: ;
			endcase
		endfunction

		function longint clamp(longint v, longint lo, longint hi);
			if (v > hi)
				return hi;
			if (v < lo)
				return lo;
			return v;
		endfunction

		function int pending();
			return expected_controls.size();
		endfunction

		// one accepted item: advance the integral and queue the control it must produce
		function void note_speeds(logic signed [SPEED_W-1:0] dem,
					  logic signed [SPEED_W-1:0] meas);
			longint          err, prop, co, lim, wind, dty;
			control_result_t r;
			err = longint'(dem) - longint'(meas);
			prop = err * longint'(kp) / Q16_ONE;
			if (prop > MAX_PROP_TERM_DEF)
				prop = MAX_PROP_TERM_DEF;
			co = clamp((prop * Q16_ONE + integral) / Q16_ONE, CO_LO, CO_HI);
			lim = longint'(sat_limit);
			wind = 0;
			if (co > lim)
				wind = lim - co;
			else if (co < -lim)
				wind = -lim - co;
			integral = clamp(integral + longint'(ki) * err + longint'(kw) * wind,
					 INTEG_LO, INTEG_HI);
			dty = (co < 0 ? longint'(brake) : longint'(drive)) * co / Q16_ONE;
			dty = clamp(dty, -MAX_DUTY_DEF, MAX_DUTY_DEF);
			dty = clamp(dty, DUTY_FIELD_MIN, DUTY_FIELD_MAX);
			r.control_output = co[CO_W-1:0];
			r.duty = dty[DUTY_W-1:0];
			expected_controls.push_back(r);
		endfunction

		task report(string what, longint want, longint got);
			$display("ERROR result %0d %s: expected %0d, got %0d", results_seen, what, want, got);
			fails++;
		endtask

		task check_result(logic signed [CO_W-1:0] co, logic signed [DUTY_W-1:0] duty);
			control_result_t want;
			if (expected_controls.size() == 0) begin
				report("control_output with no item pending", 0, co);
				return;
			end
			want = expected_controls.pop_front();
			if (co !== want.control_output)
				report("control_output", want.control_output, co);
			if (duty !== want.duty)
				report("duty", want.duty, duty);
			results_seen++;
		endtask
	endclass

endpackage

[tb/tb_pi_speed_control_antiwindup.sv]
// Testbench top: drives speed items and register writes into the PI speed loop, checks each result.
`timescale 1ns / 1ps
module tb_pi_speed_control_antiwindup;
	import pisc_pkg::*;
	import pisc_score_pkg::*;

	localparam int QUIET_LIMIT = 2000;
	localparam int LONG_HOLD = 300;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 3'd7;
	localparam logic [GAIN_W-1:0] GAIN_FULL = 24'hFFFFFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MAX = 20'sh7FFFF;
	localparam logic signed [SPEED_W-1:0] SPEED_MIN = 20'sh80000;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	pisc_in_if  in_ch();
	pisc_out_if out_ch();

	pi_speed_control_antiwindup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pi_loop_scoreboard sb;
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	int rx_hold_cycles = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic send_speeds(logic signed [SPEED_W-1:0] dem, logic signed [SPEED_W-1:0] meas);
		int gap;
		gap = tx_idle ? $urandom_range(0, 9) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.demanded_speed <= dem;
		in_ch.measured_speed <= meas;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
	endtask

	// stop offering and wait for every queued control to come back
	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		sb.set_register(idx, val);
	endtask

	task automatic load_gains(logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
				  logic [GAIN_W-1:0] kw, logic [CFG_DATA_W-1:0] lim,
				  logic [GAIN_W-1:0] drv, logic [GAIN_W-1:0] brk);
		write_reg(REG_KP, kp);
		write_reg(REG_KI, ki);
		write_reg(REG_WINDUP, kw);
		write_reg(REG_SAT_LIMIT, lim);
		write_reg(REG_DRIVE, drv);
		write_reg(REG_BRAKE, brk);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 4))
			0: return GAIN_W'($urandom_range(0, 32'hFFFFFF));
			1: return GAIN_W'($urandom_range(0, 1 << 18));
			2: return GAIN_W'($urandom_range(0, 1 << 12));
			3: return '0;
			default: return GAIN_FULL;
		endcase
	endfunction

	function automatic logic signed [SPEED_W-1:0] rand_speed();
		int v;
		v = $urandom_range(0, 8000);
		case ($urandom_range(0, 5))
			0, 1: return SPEED_W'($urandom());
			2, 3: return SPEED_W'(v - 4000);
			4: return SPEED_MAX;
			default: return SPEED_MIN;
		endcase
	endfunction

	function automatic logic signed [SPEED_W-1:0] near_speed(logic signed [SPEED_W-1:0] base);
		int off;
		int v;
		off = $urandom_range(0, 2000);
		v = int'(base) + off - 1000;
		if (v > int'(SPEED_MAX))
			v = int'(SPEED_MAX);
		if (v < int'(SPEED_MIN))
			v = int'(SPEED_MIN);
		return SPEED_W'(v);
	endfunction

	always @(posedge clk) begin
		logic took_in;
		logic took_out;
		took_in = arst_n && in_ch.valid === 1'b1 && in_ch.ready === 1'b1;
		took_out = arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1;
		if (took_in)
			sb.note_speeds(in_ch.demanded_speed, in_ch.measured_speed);
		if (took_out)
			sb.check_result(out_ch.control_output, out_ch.duty);
		if (took_in || took_out)
			quiet_cycles = 0;
		else if (arst_n)
			quiet_cycles++;
	end

	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = rx_idle ? $urandom_range(0, 9) : 0;
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			@(negedge clk);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("simulation failed");
		$finish;
	end

	initial begin
		logic signed [SPEED_W-1:0] dem;
		logic signed [SPEED_W-1:0] meas;
		logic [CFG_DATA_W-1:0]     lim;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.demanded_speed = '0;
		in_ch.measured_speed = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset gains: everything reads zero
		send_speeds('0, '0);
		send_speeds(SPEED_MAX, SPEED_MIN);
		send_speeds(SPEED_MIN, SPEED_MAX);

		// moderate gains; writes to unused indexes must not land anywhere
		drain();
		load_gains(24'd65536, 24'd655, 24'd32768, 24'd3000, 24'd131072, 24'd98304);
		write_reg(SPARE_IDX_A, GAIN_FULL);
		write_reg(SPARE_IDX_B, GAIN_FULL);
		@(negedge clk);
		cfg_we <= 1'b0;
		send_speeds('0, '0);
		send_speeds(20'sd1000, '0);
		send_speeds(-20'sd1000, '0);
		send_speeds(SPEED_MAX, SPEED_MIN);
		send_speeds(SPEED_MIN, SPEED_MAX);
		send_speeds(SPEED_MAX, SPEED_MAX);
		send_speeds(SPEED_MIN, SPEED_MIN);
		send_speeds(20'sd3000, 20'sd2999);
		send_speeds(-20'sd5, 20'sd5);

		// full gains: integral runs into its upper bound, duty clamps at its positive bound
		drain();
		load_gains(GAIN_FULL, GAIN_FULL, GAIN_FULL, 24'hFFFFFF, GAIN_FULL, GAIN_FULL);
		repeat (8) send_speeds(SPEED_MAX, SPEED_MIN);
		repeat (2) send_speeds(SPEED_MIN, SPEED_MAX);

		// zero limit: windup on every nonzero output
		drain();
		load_gains(24'd65536, 24'd6554, 24'd65536, '0, 24'd65536, 24'd65536);
		send_speeds(20'sd1000, '0);
		send_speeds(-20'sd1000, '0);
		send_speeds('0, '0);

		for (int phase = 0; phase < 8; phase++) begin
			drain();
			case (phase)
				0: load_gains(GAIN_FULL, GAIN_FULL, GAIN_FULL, 24'h7FFFFF, GAIN_FULL, GAIN_FULL);
				1: load_gains('0, '0, '0, '0, '0, '0);
				default: begin
					lim = ($urandom_range(0, 3) == 0) ? 24'h7FFFFF :
						CFG_DATA_W'($urandom_range(0, 20000));
					load_gains(rand_gain(), rand_gain(), rand_gain(), lim,
						   rand_gain(), rand_gain());
				end
			endcase
			tx_idle = (phase % 3) != 1;
			rx_idle = (phase % 4) != 2;
			for (int n = 0; n < 100; n++) begin
				if (phase == 2 && n == 40)
					rx_hold_cycles = LONG_HOLD;
				if (phase == 5 && n == 50)
					drain();
				dem = rand_speed();
				meas = ($urandom_range(0, 2) == 0) ? rand_speed() : near_speed(dem);
				send_speeds(dem, meas);
			end
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.fails == 0 && sb.pending() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
